@@ hdl/pbts_pkg.sv @@
// Shared types, constants and helper functions of the priority bitmap thread scheduler.
package pbts_pkg;

    localparam int MAX_THREADS = 64;
    localparam int LEVELS      = 32;
    localparam int TID_W       = $clog2(MAX_THREADS);
    localparam int LVL_W       = $clog2(LEVELS);
    localparam int PURGE_W     = $clog2(MAX_THREADS + 1);
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 2;
    localparam int TST_W       = 2;
    localparam int S_FIELD_W   = TID_W + LVL_W + 3;
    localparam int S_DATA_W    = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W   = TID_W + PURGE_W;
    localparam int M_DATA_W    = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_DATA_W - M_FIELD_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ  = 2'd0,
        KIND_SEL  = 2'd1,
        KIND_KILL = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    typedef enum logic [TST_W-1:0] {
        TS_NONE    = 2'd0,
        TS_READY   = 2'd1,
        TS_RUNNING = 2'd2,
        TS_DEAD    = 2'd3
    } tstat_t;

    typedef enum logic [STAT_W-1:0] {
        RES_PICKED = 2'd0,
        RES_KEPT   = 2'd1,
        RES_NONE   = 2'd2,
        RES_IDLE   = 2'd3
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RUN_CHK,
        S_APPEND_RD,
        S_APPEND_WR,
        S_PICK,
        S_PICK_HD,
        S_PICK_CHK
    } state_t;

    // lowest set bit by halving search; all-zero input gives LEVELS-1
    function automatic logic [LVL_W-1:0] first_set(input logic [LEVELS-1:0] m);
        logic [LEVELS-1:0] v;
        logic [LEVELS-1:0] lo_mask;
        logic [LVL_W-1:0]  idx;
        int                half;
        v   = m;
        idx = '0;
        for (int s = LVL_W - 1; s >= 0; s--)
        begin
            half    = 1 << s;
            lo_mask = (LEVELS'(1) << half) - LEVELS'(1);
            if ((v & lo_mask) == '0)
            begin
                idx[s] = 1'b1;
                v      = v >> half;
            end
        end
        return idx;
    endfunction

endpackage

@@ hdl/priority_bitmap_thread_scheduler_top.sv @@
// Top level of the priority bitmap thread scheduler: sequencer, run queue RAMs and thread table.
// Flow per item: kill, no-op, refused select and ignored enqueue answer from the decode
// state; enqueue reads the level's tail, then appends. A select first checks a running
// thread, keeping it or requeueing it, then picks: it reports idle when no queue is pending,
// else reads the best level's head RAM, then the head's status and link, purging dead heads.
// One item at a time: the next item is taken once the previous result has been taken.
// rst_n (asynchronous, active low) empties every queue and clears all thread states.
module priority_bitmap_thread_scheduler_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // thread_id, priority_req, yield_request, scheduler_disabled, context_mismatch
    input  logic [pbts_pkg::S_DATA_W-1:0] s_tdata,
    // kind
    input  logic [pbts_pkg::KIND_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // picked_thread, purged_count
    output logic [pbts_pkg::M_DATA_W-1:0] m_tdata,
    // status
    output logic [pbts_pkg::STAT_W-1:0]   m_tuser
);

    import pbts_pkg::*;

    state_t              state_reg, state_next;
    kind_t               kind_reg;
    logic [TID_W-1:0]    tid_reg;
    logic [LVL_W-1:0]    lvl_reg;
    logic                yield_reg, dis_reg, mis_reg;

    logic [TID_W-1:0]    app_t_reg, app_t_next;
    logic [LVL_W-1:0]    app_lvl_reg, app_lvl_next;
    logic [LVL_W-1:0]    pick_lvl_reg, pick_lvl_next;
    logic [TID_W-1:0]    h_reg, h_next;
    logic                last_reg, last_next;
    logic [PURGE_W-1:0]  purged_reg, purged_next;

    logic [LEVELS-1:0]      pending_reg, pending_next;
    logic [MAX_THREADS-1:0] queued_reg, queued_next;
    logic [MAX_THREADS-1:0] stv_reg, stv_next;
    logic                   run_valid_reg, run_valid_next;
    logic [TID_W-1:0]       run_id_reg, run_id_next;

    logic                out_valid_reg, out_valid_next;
    res_t                out_stat_reg, out_stat_next;
    logic [TID_W-1:0]    out_pick_reg, out_pick_next;
    logic [PURGE_W-1:0]  out_purged_reg, out_purged_next;

    logic                accept;
    logic [LVL_W-1:0]    best_lvl;
    tstat_t              cur_st;

    logic                st_we;
    logic [TID_W-1:0]    st_waddr, st_raddr;
    logic [TST_W-1:0]    st_wdata, st_rdata;
    logic                nx_we;
    logic [TID_W-1:0]    nx_waddr, nx_wdata, nx_rdata;
    logic                lv_we;
    logic [TID_W-1:0]    lv_waddr;
    logic [LVL_W-1:0]    lv_wdata, lv_rdata;
    logic                hd_we;
    logic [LVL_W-1:0]    hd_waddr, hd_raddr;
    logic [TID_W-1:0]    hd_wdata, hd_rdata;
    logic                tl_we;
    logic [LVL_W-1:0]    tl_waddr, tl_raddr;
    logic [TID_W-1:0]    tl_wdata, tl_rdata;

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_purged_reg, out_pick_reg};
    assign m_tuser  = out_stat_reg;
    assign best_lvl = first_set(pending_reg);

    assign st_raddr = (state_reg == S_PICK_HD) ? hd_rdata : run_id_reg;

    // per-thread status, link and level tables
    pbts_ram #(.WIDTH(TST_W), .DEPTH(MAX_THREADS)) u_status_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    pbts_ram #(.WIDTH(TID_W), .DEPTH(MAX_THREADS)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (hd_rdata),
        .rdata (nx_rdata)
    );

    pbts_ram #(.WIDTH(LVL_W), .DEPTH(MAX_THREADS)) u_level_ram (
        .clk   (clk),
        .we    (lv_we),
        .waddr (lv_waddr),
        .wdata (lv_wdata),
        .raddr (run_id_reg),
        .rdata (lv_rdata)
    );

    // queue heads and tails; a queue is empty exactly when its pending bit is clear
    pbts_ram #(.WIDTH(TID_W), .DEPTH(LEVELS)) u_head_ram (
        .clk   (clk),
        .we    (hd_we),
        .waddr (hd_waddr),
        .wdata (hd_wdata),
        .raddr (hd_raddr),
        .rdata (hd_rdata)
    );

    pbts_ram #(.WIDTH(TID_W), .DEPTH(LEVELS)) u_tail_ram (
        .clk   (clk),
        .we    (tl_we),
        .waddr (tl_waddr),
        .wdata (tl_wdata),
        .raddr (tl_raddr),
        .rdata (tl_rdata)
    );

    assign hd_raddr = best_lvl;
    assign tl_raddr = (state_reg == S_APPEND_RD) ? app_lvl_reg : best_lvl;
    assign cur_st   = (state_reg == S_PICK_CHK) ?
                      (stv_reg[h_reg] ? tstat_t'(st_rdata) : TS_NONE) :
                      (stv_reg[run_id_reg] ? tstat_t'(st_rdata) : TS_NONE);

    always_comb
    begin
        state_next      = state_reg;
        app_t_next      = app_t_reg;
        app_lvl_next    = app_lvl_reg;
        pick_lvl_next   = pick_lvl_reg;
        h_next          = h_reg;
        last_next       = last_reg;
        purged_next     = purged_reg;
        pending_next    = pending_reg;
        queued_next     = queued_reg;
        stv_next        = stv_reg;
        run_valid_next  = run_valid_reg;
        run_id_next     = run_id_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_stat_next   = out_stat_reg;
        out_pick_next   = out_pick_reg;
        out_purged_next = out_purged_reg;

        st_we    = 1'b0;
        st_waddr = app_t_reg;
        st_wdata = TS_READY;
        nx_we    = 1'b0;
        nx_waddr = tl_rdata;
        nx_wdata = app_t_reg;
        lv_we    = 1'b0;
        lv_waddr = app_t_reg;
        lv_wdata = app_lvl_reg;
        hd_we    = 1'b0;
        hd_waddr = app_lvl_reg;
        hd_wdata = app_t_reg;
        tl_we    = 1'b0;
        tl_waddr = app_lvl_reg;
        tl_wdata = app_t_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    purged_next = '0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                out_stat_next   = RES_NONE;
                out_pick_next   = '0;
                out_purged_next = '0;
                unique case (kind_reg)
                    KIND_ENQ:
                    begin
                        if (!queued_reg[tid_reg] && !(run_valid_reg && run_id_reg == tid_reg))
                        begin
                            app_t_next   = tid_reg;
                            app_lvl_next = lvl_reg;
                            state_next   = S_APPEND_RD;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    KIND_KILL:
                    begin
                        st_we             = 1'b1;
                        st_waddr          = tid_reg;
                        st_wdata          = TS_DEAD;
                        stv_next[tid_reg] = 1'b1;
                        out_valid_next    = 1'b1;
                        state_next        = S_IDLE;
                    end
                    KIND_SEL:
                    begin
                        if (dis_reg || mis_reg)
                        begin
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else if (run_valid_reg)
                        begin
                            state_next = S_RUN_CHK;
                        end
                        else
                        begin
                            state_next = S_PICK;
                        end
                    end
                    default:
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                endcase
            end

            S_RUN_CHK:
            begin
                if (cur_st == TS_RUNNING)
                begin
                    if (!yield_reg && (pending_reg == '0 || lv_rdata <= best_lvl))
                    begin
                        out_stat_next  = RES_KEPT;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        app_t_next   = run_id_reg;
                        app_lvl_next = lv_rdata;
                        state_next   = S_APPEND_RD;
                    end
                end
                else
                begin
                    state_next = S_PICK;
                end
            end

            S_APPEND_RD:
            begin
                state_next = S_APPEND_WR;
            end

            S_APPEND_WR:
            begin
                if (pending_reg[app_lvl_reg])
                begin
                    nx_we = 1'b1;
                end
                else
                begin
                    hd_we = 1'b1;
                end
                tl_we                     = 1'b1;
                lv_we                     = 1'b1;
                st_we                     = 1'b1;
                stv_next[app_t_reg]       = 1'b1;
                queued_next[app_t_reg]    = 1'b1;
                pending_next[app_lvl_reg] = 1'b1;
                if (kind_reg == KIND_SEL)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_PICK:
            begin
                if (pending_reg == '0)
                begin
                    run_valid_next  = 1'b0;
                    out_stat_next   = RES_IDLE;
                    out_pick_next   = '0;
                    out_purged_next = purged_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    pick_lvl_next = best_lvl;
                    state_next    = S_PICK_HD;
                end
            end

            S_PICK_HD:
            begin
                h_next     = hd_rdata;
                last_next  = (hd_rdata == tl_rdata);
                state_next = S_PICK_CHK;
            end

            S_PICK_CHK:
            begin
                // pop the head; the tail marks the end of the list
                if (last_reg)
                begin
                    pending_next[pick_lvl_reg] = 1'b0;
                end
                else
                begin
                    hd_we    = 1'b1;
                    hd_waddr = pick_lvl_reg;
                    hd_wdata = nx_rdata;
                end
                queued_next[h_reg] = 1'b0;
                if (cur_st == TS_DEAD || cur_st == TS_NONE)
                begin
                    purged_next = purged_reg + PURGE_W'(1);
                    state_next  = S_PICK;
                end
                else
                begin
                    st_we           = 1'b1;
                    st_waddr        = h_reg;
                    st_wdata        = TS_RUNNING;
                    run_valid_next  = 1'b1;
                    run_id_next     = h_reg;
                    out_stat_next   = RES_PICKED;
                    out_pick_next   = h_reg;
                    out_purged_next = purged_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pending_reg   <= '0;
            queued_reg    <= '0;
            stv_reg       <= '0;
            run_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            queued_reg    <= queued_next;
            stv_reg       <= stv_next;
            run_valid_reg <= run_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_t'(s_tuser);
            tid_reg   <= s_tdata[TID_W-1:0];
            lvl_reg   <= s_tdata[TID_W +: LVL_W];
            yield_reg <= s_tdata[TID_W + LVL_W];
            dis_reg   <= s_tdata[TID_W + LVL_W + 1];
            mis_reg   <= s_tdata[TID_W + LVL_W + 2];
        end
        app_t_reg      <= app_t_next;
        app_lvl_reg    <= app_lvl_next;
        pick_lvl_reg   <= pick_lvl_next;
        h_reg          <= h_next;
        last_reg       <= last_next;
        purged_reg     <= purged_next;
        run_id_reg     <= run_id_next;
        out_stat_reg   <= out_stat_next;
        out_pick_reg   <= out_pick_next;
        out_purged_reg <= out_purged_next;
    end

endmodule

@@ hdl/pbts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/pbts_checker.sv @@
// Port-level assertions for the priority bitmap thread scheduler, bound to the top level.
module pbts_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [pbts_pkg::S_DATA_W-1:0] s_tdata,
    input logic [pbts_pkg::KIND_W-1:0]   s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pbts_pkg::M_DATA_W-1:0] m_tdata,
    input logic [pbts_pkg::STAT_W-1:0]   m_tuser
);

    import pbts_pkg::*;

    // one item in flight: no intake while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready straight after an accepted item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != RES_PICKED) |-> (m_tdata[TID_W-1:0] == '0))
        else $error("picked thread set without a pick");

    a_purge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == RES_KEPT || m_tuser == RES_NONE))
            |-> (m_tdata[TID_W +: PURGE_W] == '0))
        else $error("purge count set without a pick pass");

endmodule

bind priority_bitmap_thread_scheduler_top pbts_checker u_pbts_checker (.*);

@@ bench/priority_bitmap_thread_scheduler_top_test.sv @@
// Self-checking testbench for the priority bitmap thread scheduler, with its own run queue predictor.
`timescale 1ns / 1ps

module priority_bitmap_thread_scheduler_top_test;
    import pbts_pkg::*;

    localparam logic [TID_W:0] NO_THREAD   = '1;
    localparam int             CYCLE_LIMIT = 1000000;
    localparam int             SETTLE      = 300;

    typedef struct packed {
        res_t               status;
        logic [TID_W-1:0]   picked;
        logic [PURGE_W-1:0] purged;
    } outcome_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]   m_tuser;

    // predictor state
    logic [LEVELS-1:0] pend_bits;
    logic [TID_W:0]    q_first [LEVELS];
    logic [TID_W:0]    q_last [LEVELS];
    logic [TID_W:0]    link_next [MAX_THREADS];
    logic [TID_W:0]    link_prev [MAX_THREADS];
    tstat_t            t_state [MAX_THREADS];
    logic [LVL_W-1:0]  t_level [MAX_THREADS];
    bit                t_linked [MAX_THREADS];
    logic [TID_W:0]    on_cpu;

    outcome_t expected_outcomes[$];
    int       errors;
    int       cycle_count;
    int       hold_off_cycles;
    bit       src_flat;
    bit       snk_flat;

    priority_bitmap_thread_scheduler_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    function automatic void clear_queues();
        pend_bits = '0;
        on_cpu    = NO_THREAD;
        for (int l = 0; l < LEVELS; l++)
        begin
            q_first[l] = NO_THREAD;
            q_last[l]  = NO_THREAD;
        end
        for (int t = 0; t < MAX_THREADS; t++)
        begin
            link_next[t] = '0;
            link_prev[t] = '0;
            t_state[t]   = TS_NONE;
            t_level[t]   = '0;
            t_linked[t]  = 1'b0;
        end
    endfunction

    function automatic int top_level();
        for (int l = 0; l < LEVELS; l++)
            if (pend_bits[l])
                return l;
        return LEVELS;
    endfunction

    function automatic void link_at_tail(logic [TID_W:0] t, int lvl);
        if (q_last[lvl] == NO_THREAD)
            q_first[lvl] = t;
        else
            link_next[q_last[lvl][TID_W-1:0]] = t;
        link_prev[t[TID_W-1:0]] = q_last[lvl];
        link_next[t[TID_W-1:0]] = NO_THREAD;
        q_last[lvl]             = t;
        t_level[t[TID_W-1:0]]   = lvl[LVL_W-1:0];
        t_linked[t[TID_W-1:0]]  = 1'b1;
        pend_bits[lvl]          = 1'b1;
    endfunction

    function automatic logic [TID_W:0] unlink_head(int lvl);
        logic [TID_W:0] h;
        logic [TID_W:0] nx;
        h  = q_first[lvl];
        nx = link_next[h[TID_W-1:0]];
        if (nx != NO_THREAD)
            link_prev[nx[TID_W-1:0]] = NO_THREAD;
        else
        begin
            q_last[lvl]    = NO_THREAD;
            pend_bits[lvl] = 1'b0;
        end
        q_first[lvl]           = nx;
        t_linked[h[TID_W-1:0]] = 1'b0;
        return h;
    endfunction

    function automatic void schedule_step(kind_t k, logic [TID_W-1:0] tid,
                                          logic [LVL_W-1:0] prio, logic yld,
                                          logic dis, logic mis);
        outcome_t       o;
        int             rl;
        int             lvl;
        bit             go;
        bit             done;
        logic [TID_W:0] h;
        o.status = RES_NONE;
        o.picked = '0;
        o.purged = '0;
        case (k)
            KIND_ENQ:
                if (!t_linked[tid] && {1'b0, tid} != on_cpu)
                begin
                    t_state[tid] = TS_READY;
                    link_at_tail({1'b0, tid}, int'(prio));
                end
            KIND_KILL:
                t_state[tid] = TS_DEAD;
            KIND_SEL:
                if (!dis && !mis)
                begin
                    go = 1'b1;
                    if (on_cpu != NO_THREAD && t_state[on_cpu[TID_W-1:0]] == TS_RUNNING)
                    begin
                        rl = int'(t_level[on_cpu[TID_W-1:0]]);
                        if (!yld && rl <= top_level())
                        begin
                            o.status = RES_KEPT;
                            go       = 1'b0;
                        end
                        else
                        begin
                            t_state[on_cpu[TID_W-1:0]] = TS_READY;
                            link_at_tail(on_cpu, rl);
                        end
                    end
                    if (go)
                    begin
                        o.status = RES_IDLE;
                        done     = 1'b0;
                        while (!done)
                        begin
                            lvl = top_level();
                            if (lvl >= LEVELS)
                                done = 1'b1;
                            else if (q_first[lvl] == NO_THREAD)
                                pend_bits[lvl] = 1'b0;
                            else
                            begin
                                h = unlink_head(lvl);
                                if (t_state[h[TID_W-1:0]] == TS_DEAD ||
                                    t_state[h[TID_W-1:0]] == TS_NONE)
                                    o.purged++;
                                else
                                begin
                                    t_state[h[TID_W-1:0]] = TS_RUNNING;
                                    on_cpu   = h;
                                    o.status = RES_PICKED;
                                    o.picked = h[TID_W-1:0];
                                    done     = 1'b1;
                                end
                            end
                        end
                        if (o.status == RES_IDLE)
                            on_cpu = NO_THREAD;
                    end
                end
            default:
                ;
        endcase
        expected_outcomes.push_back(o);
    endfunction

    task automatic send_item(kind_t k, logic [TID_W-1:0] tid, logic [LVL_W-1:0] prio,
                             logic yld, logic dis, logic mis);
        int gap;
        gap = src_flat ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= S_DATA_W'({mis, dis, yld, prio, tid});
        do
            @(posedge clk);
        while (!s_tready);
        schedule_step(k, tid, prio, yld, dis, mis);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        src_flat = 1'b0;
        snk_flat = 1'b0;
        send_item(KIND_SEL,  6'd0,  5'd0,  1'b0, 1'b0, 1'b0);
        send_item(KIND_ENQ,  6'd0,  5'd31, 1'b0, 1'b0, 1'b0);
        send_item(KIND_ENQ,  6'd63, 5'd0,  1'b0, 1'b0, 1'b0);
        send_item(KIND_ENQ,  6'd21, 5'd0,  1'b0, 1'b0, 1'b0);
        send_item(KIND_ENQ,  6'd42, 5'd15, 1'b0, 1'b0, 1'b0);
        send_item(KIND_SEL,  6'd0,  5'd0,  1'b0, 1'b0, 1'b0);
        send_item(KIND_SEL,  6'd0,  5'd0,  1'b0, 1'b0, 1'b0);
        // double enqueue: running, then already queued
        send_item(KIND_ENQ,  6'd63, 5'd4,  1'b0, 1'b0, 1'b0);
        send_item(KIND_ENQ,  6'd21, 5'd9,  1'b0, 1'b0, 1'b0);
        send_item(KIND_SEL,  6'd0,  5'd0,  1'b1, 1'b0, 1'b0);
        send_item(KIND_SEL,  6'd0,  5'd0,  1'b0, 1'b1, 1'b0);
        send_item(KIND_SEL,  6'd0,  5'd0,  1'b0, 1'b0, 1'b1);
        send_item(KIND_SEL,  6'h3F, 5'h1F, 1'b1, 1'b1, 1'b1);
        // killed while queued, purged at the head
        send_item(KIND_KILL, 6'd63, 5'd0,  1'b0, 1'b0, 1'b0);
        send_item(KIND_KILL, 6'd42, 5'd0,  1'b0, 1'b0, 1'b0);
        send_item(KIND_SEL,  6'd0,  5'd0,  1'b1, 1'b0, 1'b0);
        // killed while running
        send_item(KIND_KILL, 6'd21, 5'd0,  1'b0, 1'b0, 1'b0);
        send_item(KIND_SEL,  6'd0,  5'd0,  1'b0, 1'b0, 1'b0);
        send_item(KIND_ENQ,  6'd42, 5'd31, 1'b0, 1'b0, 1'b0);
        send_item(KIND_NOP,  6'h3F, 5'h1F, 1'b1, 1'b1, 1'b1);
        send_item(KIND_KILL, 6'd5,  5'd0,  1'b0, 1'b0, 1'b0);
        send_item(KIND_ENQ,  6'd5,  5'd7,  1'b0, 1'b0, 1'b0);
        send_item(KIND_SEL,  6'd0,  5'd0,  1'b0, 1'b0, 1'b0);
        send_item(KIND_SEL,  6'd0,  5'd0,  1'b1, 1'b0, 1'b0);
        send_item(KIND_KILL, 6'd5,  5'd0,  1'b0, 1'b0, 1'b0);
        send_item(KIND_SEL,  6'd0,  5'd0,  1'b0, 1'b0, 1'b0);
        wait_quiet();
    endtask

    task automatic test_mass_purge();
        for (int t = 0; t < MAX_THREADS; t++)
            send_item(KIND_ENQ, t[TID_W-1:0], LVL_W'($urandom_range(0, LEVELS - 1)),
                      1'b0, 1'b0, 1'b0);
        for (int t = 0; t < MAX_THREADS; t++)
            send_item(KIND_KILL, t[TID_W-1:0], '0, 1'b0, 1'b0, 1'b0);
        send_item(KIND_SEL, '0, '0, 1'b0, 1'b0, 1'b0);
        send_item(KIND_SEL, '0, '0, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic(int n, int pool, int prio_hi);
        int    r;
        int    base;
        kind_t k;
        base = $urandom_range(0, MAX_THREADS - 1);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 42)
                k = KIND_ENQ;
            else if (r < 78)
                k = KIND_SEL;
            else if (r < 94)
                k = KIND_KILL;
            else
                k = KIND_NOP;
            send_item(k, TID_W'((base + $urandom_range(0, pool - 1)) % MAX_THREADS),
                      LVL_W'($urandom_range(0, prio_hi)),
                      $urandom_range(0, 3) == 0,
                      $urandom_range(0, 9) == 0,
                      $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 79) == 0)
                src_flat = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 79) == 0)
                snk_flat = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 149) == 0)
                wait_quiet();
        end
    endtask

    task automatic test_backpressure();
        wait_quiet();
        src_flat        = 1'b1;
        hold_off_cycles = 300;
        test_random_traffic(40, 12, 5);
        wait_quiet();
        src_flat = 1'b0;
    endtask

    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
                stall = snk_flat ? 0 : $urandom_range(0, 17);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item, status %0d data %h", $time, m_tuser, m_tdata);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (m_tuser != want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d got %0d", $time, want.status, m_tuser);
                end
                if (m_tdata[TID_W-1:0] != want.picked)
                begin
                    errors++;
                    $display("%0t: picked_thread expected %0d got %0d", $time, want.picked,
                             m_tdata[TID_W-1:0]);
                end
                if (m_tdata[TID_W +: PURGE_W] != want.purged)
                begin
                    errors++;
                    $display("%0t: purged_count expected %0d got %0d", $time, want.purged,
                             m_tdata[TID_W +: PURGE_W]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        errors          = 0;
        cycle_count     = 0;
        hold_off_cycles = 0;
        src_flat        = 1'b0;
        snk_flat        = 1'b0;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = KIND_NOP;
        clear_queues();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_mass_purge();
        test_random_traffic(300, 8, 3);
        test_backpressure();
        test_random_traffic(300, 64, 31);
        test_mass_purge();
        test_random_traffic(300, 16, 7);

        wait_quiet();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
